// File: design/hpa_pkg.sv
// ============================================================================
// hpa_pkg: shared types, constants and helpers for the hexagon lookup
// Fixed widths of the pixel-to-hexagon datapath, the numerator item that
// travels through the queue, and the rounding and clamping helpers.
// ============================================================================
`default_nettype none

package hpa_pkg;

    localparam int COORD_FRAC_BITS_DEF = 12;
    localparam int QUEUE_DEPTH_DEF     = 4;

    localparam int IN_W    = 32;
    localparam int OUT_W   = 22;
    localparam int RECIP_W = 32;
    localparam int SQ_W    = 18;

    localparam logic [RECIP_W-1:0]     RECIP_RESET = 32'd14316558;
    localparam logic signed [SQ_W-1:0] SQRT3_Q16   = 18'sd113512;

    // Numerators carry the input fraction plus 16 bits.
    localparam int NUM_W  = IN_W + SQ_W;
    localparam int LO_W   = 32;
    localparam int HI_W   = NUM_W - LO_W;
    localparam int PROD_W = NUM_W + RECIP_W + 1;

    // Fractional q, r and s at 16 fraction bits.
    localparam int FV_W  = 53;
    localparam int RND_W = FV_W - 15;
    localparam int ERR_W = 16;

    localparam int OUT_MAX = 2 ** (OUT_W - 1) - 1;
    localparam int OUT_MIN = -(2 ** (OUT_W - 1));

    localparam logic signed [RND_W:0] SAT_HI = (RND_W + 1)'(OUT_MAX);
    localparam logic signed [RND_W:0] SAT_LO = (RND_W + 1)'(OUT_MIN);

    typedef struct packed {
        logic signed [NUM_W-1:0] num_q;
        logic signed [NUM_W-1:0] num_r;
    } numer_t;

    // Round half up: floor((v + 2^15) / 2^16).
    function automatic logic signed [RND_W-1:0] round_q16(input logic signed [FV_W-1:0] v);
        logic signed [FV_W:0] sum;
        begin
            sum = (FV_W + 1)'(v) + (FV_W + 1)'(32768);
            return RND_W'(sum >>> 16);
        end
    endfunction

    // Magnitude of the rounding error, which depends only on the fraction bits.
    function automatic logic [ERR_W-1:0] round_err(input logic [15:0] frac);
        logic [15:0] t;
        begin
            t = frac ^ 16'h8000;
            if (t <= 16'h8000) begin
                return ERR_W'(16'h8000 - t);
            end else begin
                return ERR_W'(t - 16'h8000);
            end
        end
    endfunction

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [RND_W:0] v);
        begin
            if (v > SAT_HI) begin
                return SAT_HI[OUT_W-1:0];
            end else if (v < SAT_LO) begin
                return SAT_LO[OUT_W-1:0];
            end else begin
                return v[OUT_W-1:0];
            end
        end
    endfunction

endpackage

`default_nettype wire

// File: design/hpa_front.sv
// ============================================================================
// hpa_front: input stage of the hexagon lookup
// Accepts points, swaps the axes and forms the q and r numerators, then
// hands each item to the queue.
// ============================================================================
`default_nettype none

module hpa_front
    import hpa_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic signed [IN_W-1:0]  s_world_x,
    input  wire logic signed [IN_W-1:0]  s_world_y,
    output logic                         push_valid,
    input  wire logic                    push_ready,
    output numer_t                       push_data
);

    logic   f_valid_reg;
    numer_t numer_reg;
    numer_t numer_next;
    logic   accept;

    logic signed [NUM_W-1:0] cx_mul;

    // Cartesian x is world_y and cartesian y is world_x.
    always_comb begin
        cx_mul           = s_world_y * SQRT3_Q16;
        numer_next.num_q = cx_mul - (NUM_W'(s_world_x) <<< 16);
        numer_next.num_r = NUM_W'(s_world_x) <<< 17;
    end

    assign s_ready    = !f_valid_reg || push_ready;
    assign accept     = s_valid && s_ready;
    assign push_valid = f_valid_reg;
    assign push_data  = numer_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (accept) begin
            f_valid_reg <= 1'b1;
        end else if (push_ready) begin
            f_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            numer_reg <= numer_next;
        end
    end

endmodule

`default_nettype wire

// File: design/hpa_queue.sv
// ============================================================================
// hpa_queue: item queue between front and back
// A small circular buffer that lets the input side and the arithmetic
// pipeline stall independently.
// ============================================================================
`default_nettype none

module hpa_queue
    import hpa_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   push_valid,
    output logic        push_ready,
    input  wire numer_t push_data,
    output logic        pop_valid,
    input  wire logic   pop_ready,
    output numer_t      pop_data
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    numer_t            entry_reg [QUEUE_DEPTH];
    logic [IDX_W-1:0]  wr_ptr_reg;
    logic [IDX_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [IDX_W-1:0]  wr_ptr_next;
    logic [IDX_W-1:0]  rd_ptr_next;
    logic              push;
    logic              pop;

    assign push_ready = count_reg != CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    assign wr_ptr_next = (wr_ptr_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue fill count above depth");

    a_count_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue fill count missed a push");

    a_count_down: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !push) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue fill count missed a pop");

endmodule

`default_nettype wire

// File: design/hpa_back.sv
// ============================================================================
// hpa_back: arithmetic pipeline of the hexagon lookup
// Scales the numerators by the reciprocal, rounds q, r and s, rebuilds the
// component with the largest error and clamps the result.
// ============================================================================
`default_nettype none

module hpa_back
    import hpa_pkg::*;
#(
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic [RECIP_W-1:0]       recip,
    input  wire logic                     pop_valid,
    output logic                          pop_ready,
    input  wire numer_t                   pop_data,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic signed [OUT_W-1:0]       m_axial_q,
    output logic signed [OUT_W-1:0]       m_axial_r
);

    localparam int SHIFT = COORD_FRAC_BITS + 32;

    logic adv;

    logic                          b1_valid_reg;
    logic signed [HI_W+RECIP_W:0]  p_hi_q_reg, p_hi_r_reg;
    logic signed [HI_W+RECIP_W:0]  p_hi_q_next, p_hi_r_next;
    logic [LO_W+RECIP_W-1:0]       p_lo_q_reg, p_lo_r_reg;
    logic [LO_W+RECIP_W-1:0]       p_lo_q_next, p_lo_r_next;
    logic signed [RECIP_W:0]       recip_s;

    logic                          b2_valid_reg;
    logic signed [PROD_W-1:0]      prod_q, prod_r;
    logic signed [FV_W-1:0]        fq_reg, fr_reg, fs_reg;
    logic signed [FV_W-1:0]        fq_next, fr_next, fs_next;

    logic                          b3_valid_reg;
    logic signed [RND_W-1:0]       q_rnd_reg, r_rnd_reg, s_rnd_reg;
    logic [ERR_W-1:0]              eq_reg, er_reg, es_reg;

    logic                          m_valid_reg;
    logic signed [OUT_W-1:0]       m_axial_q_reg, m_axial_r_reg;
    logic signed [OUT_W-1:0]       m_axial_q_next, m_axial_r_next;
    logic signed [RND_W:0]         q_ext, r_ext;

    // The whole pipeline moves together whenever the output register can load.
    assign adv       = !m_valid_reg || m_ready;
    assign pop_ready = adv;

    // Stage 1: each numerator is split at bit 32 so no product exceeds 32 by 33.
    always_comb begin
        recip_s     = {1'b0, recip};
        p_hi_q_next = $signed(pop_data.num_q[NUM_W-1:LO_W]) * recip_s;
        p_hi_r_next = $signed(pop_data.num_r[NUM_W-1:LO_W]) * recip_s;
        p_lo_q_next = pop_data.num_q[LO_W-1:0] * recip;
        p_lo_r_next = pop_data.num_r[LO_W-1:0] * recip;
    end

    // Stage 2: recombine and floor down to 16 fraction bits.
    always_comb begin
        prod_q  = (PROD_W'(p_hi_q_reg) <<< LO_W) + PROD_W'({1'b0, p_lo_q_reg});
        prod_r  = (PROD_W'(p_hi_r_reg) <<< LO_W) + PROD_W'({1'b0, p_lo_r_reg});
        fq_next = FV_W'(prod_q >>> SHIFT);
        fr_next = FV_W'(prod_r >>> SHIFT);
        fs_next = -fq_next - fr_next;
    end

    // Stage 4: on a tie q is kept before r, and r before s.
    always_comb begin
        q_ext = (RND_W + 1)'(q_rnd_reg);
        r_ext = (RND_W + 1)'(r_rnd_reg);
        if (eq_reg > er_reg && eq_reg > es_reg) begin
            q_ext = -((RND_W + 1)'(r_rnd_reg) + (RND_W + 1)'(s_rnd_reg));
        end else if (er_reg > es_reg) begin
            r_ext = -((RND_W + 1)'(q_rnd_reg) + (RND_W + 1)'(s_rnd_reg));
        end
        m_axial_q_next = sat_out(q_ext);
        m_axial_r_next = sat_out(r_ext);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (adv) begin
            b1_valid_reg <= pop_valid;
            b2_valid_reg <= b1_valid_reg;
            b3_valid_reg <= b2_valid_reg;
            m_valid_reg  <= b3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p_hi_q_reg    <= p_hi_q_next;
            p_hi_r_reg    <= p_hi_r_next;
            p_lo_q_reg    <= p_lo_q_next;
            p_lo_r_reg    <= p_lo_r_next;
            fq_reg        <= fq_next;
            fr_reg        <= fr_next;
            fs_reg        <= fs_next;
            q_rnd_reg     <= round_q16(fq_reg);
            r_rnd_reg     <= round_q16(fr_reg);
            s_rnd_reg     <= round_q16(fs_reg);
            eq_reg        <= round_err(fq_reg[15:0]);
            er_reg        <= round_err(fr_reg[15:0]);
            es_reg        <= round_err(fs_reg[15:0]);
            m_axial_q_reg <= m_axial_q_next;
            m_axial_r_reg <= m_axial_r_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_axial_q = m_axial_q_reg;
    assign m_axial_r = m_axial_r_reg;

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(b2_valid_reg) && $stable(b3_valid_reg))
        else $error("pipeline stage moved during a stall");

    a_last_stage_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && b3_valid_reg) |=> m_valid_reg)
        else $error("finished item did not reach the output register");

    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && !b3_valid_reg) |=> !m_valid_reg)
        else $error("output register shows an item that was never computed");

endmodule

`default_nettype wire

// File: design/hex_pixel_to_axial_round.sv
// ============================================================================
// hex_pixel_to_axial_round: world point to pointy-top hexagon lookup
// Maps a Q20.12 world point to the axial (q, r) of its containing hexagon.
// ============================================================================
// One item enters per clock when the result side keeps up; there is no state
// between items. An accepted point passes the numerator register, then the
// four-entry queue, then the back pipeline registers (split reciprocal
// multiply, recombine and floor, round half up with error magnitudes), before
// the rebuild and clamp load the output register. The four partial products
// of the multiply stage, none wider than 32 by 33 bits, set the cycle time.
// The reciprocal register resets to a hex size of about 100 and should be
// written only while no item is in flight; cfg_ready is always high.
`default_nettype none

module hex_pixel_to_axial_round
    import hpa_pkg::*;
#(
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [RECIP_W-1:0]       cfg_inverse_three_size,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic signed [IN_W-1:0]   s_world_x,
    input  wire logic signed [IN_W-1:0]   s_world_y,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic signed [OUT_W-1:0]       m_axial_q,
    output logic signed [OUT_W-1:0]       m_axial_r
);

    logic [RECIP_W-1:0] inverse_three_size_reg;

    logic   push_valid, push_ready;
    numer_t push_data;
    logic   pop_valid, pop_ready;
    numer_t pop_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inverse_three_size_reg <= RECIP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            inverse_three_size_reg <= cfg_inverse_three_size;
        end
    end

    hpa_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_world_x  (s_world_x),
        .s_world_y  (s_world_y),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    hpa_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    hpa_back #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .recip     (inverse_three_size_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_axial_q (m_axial_q),
        .m_axial_r (m_axial_r)
    );

endmodule

`default_nettype wire
